// ----- hw/rtl/prm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prm_pkg: shared types and constants for the pulse RPM meter
// Holds the control-store layout, the microprogram and the register map.
// ---------------------------------------------------------------------------
package prm_pkg;

	localparam int unsigned STEP_W = 3;
	localparam int unsigned ITER_W = 6;

	localparam logic [15:0] RPM_SCALE = 16'd60000;
	localparam logic [15:0] RPM_SAT   = 16'hFFFF;

	localparam logic [15:0] PPR_RESET    = 16'd1;
	localparam logic [15:0] SAMPLE_RESET = 16'd1000;

	// register index taken from paddr[2]
	localparam logic REG_PPR            = 1'b0;
	localparam logic REG_SAMPLE_TIME_MS = 1'b1;

	localparam logic [ITER_W-1:0] ITER_REVS = ITER_W'(16);
	localparam logic [ITER_W-1:0] ITER_RPM  = ITER_W'(32);

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_LD_REVS,
		OP_DIV,
		OP_MUL,
		OP_SAT,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_GOTO,
		COND_ACCEPT,
		COND_LOOP,
		COND_OUT
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_LD   = 3'd1;
	localparam step_t STEP_DIV1 = 3'd2;
	localparam step_t STEP_MUL  = 3'd3;
	localparam step_t STEP_DIV2 = 3'd4;
	localparam step_t STEP_SAT  = 3'd5;
	localparam step_t STEP_OUT  = 3'd6;

	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t cw;
		case (step)
			STEP_IDLE: cw = '{op: OP_ACCEPT, cond: COND_ACCEPT, target: STEP_OUT};
			STEP_LD:   cw = '{op: OP_LD_REVS, cond: COND_NEXT, target: STEP_IDLE};
			STEP_DIV1: cw = '{op: OP_DIV, cond: COND_LOOP, target: STEP_DIV1};
			STEP_MUL:  cw = '{op: OP_MUL, cond: COND_NEXT, target: STEP_IDLE};
			STEP_DIV2: cw = '{op: OP_DIV, cond: COND_LOOP, target: STEP_DIV2};
			STEP_SAT:  cw = '{op: OP_SAT, cond: COND_NEXT, target: STEP_IDLE};
			STEP_OUT:  cw = '{op: OP_OUT, cond: COND_OUT, target: STEP_IDLE};
			default:   cw = '{op: OP_NOP, cond: COND_GOTO, target: STEP_IDLE};
		endcase
		return cw;
	endfunction

endpackage

// ----- hw/rtl/pulse_rpm_meter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pulse_rpm_meter: tachometer by pulse counting over a measured time
// Microcoded sequencer driving a counter set and a shared restoring divider.
// ---------------------------------------------------------------------------
// Usage:
//  - Input stream s_*: one transaction per sample with the sensor level, a
//    millisecond tick strobe and a read request. Output stream m_*: one
//    transaction per input with the held rpm and an updated flag.
//  - An item without a recomputation is accepted at the first step and then
//    loaded into the output register at the output step. A read that
//    recomputes loads the pulse count, runs a 16-step divide for revolutions,
//    a multiply by 60000, then a 32-step divide by the elapsed milliseconds,
//    and saturates the result before the output step; both divides use the
//    single shared divider.
//  - One item is in flight at a time; s_tready is high only while the
//    sequencer waits at its first step.
//  - The result sits in an output register, so the next input is accepted
//    while an earlier result waits for m_tready. When the receiver stalls
//    with that register full, the sequencer holds at its output step.
//  - Reset clears all counters and the held speed, and loads one pulse per
//    revolution and a 1000 ms sample time. APB writes take effect at once
//    and are meant to happen while the block is idle.
// ---------------------------------------------------------------------------
module pulse_rpm_meter #(
	parameter int unsigned MAX_PULSES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pulse_level, [1] ms_tick, [2] read_request
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] rpm
	output logic        m_tuser    // [0] updated
);
	import prm_pkg::*;

	localparam logic [15:0] MaxPulses = 16'(MAX_PULSES);

	logic [15:0] ppr_q;
	logic [15:0] sample_q;

	step_t       step_q;
	step_t       step_d;
	ctrl_word_t  cw;

	logic        last_level_q;
	logic [15:0] pulse_count_q;
	logic [31:0] elapsed_q;
	logic [15:0] interval_q;
	logic [15:0] held_q;
	logic        upd_q;

	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [ITER_W-1:0] iter_q;

	logic        out_full_q;
	logic [15:0] rpm_q;
	logic        updated_q;

	logic        in_acc;
	logic        pulse_level;
	logic        ms_tick;
	logic        read_request;
	logic [15:0] pc_new;
	logic [31:0] el_new;
	logic [15:0] iv_new;
	logic        hit_count;
	logic        hit_interval;
	logic        upd_new;

	logic [32:0] rem_sh;
	logic [33:0] trial;
	logic        trial_ge;
	logic [31:0] prod;
	logic        cfg_wr;

	assign pulse_level  = s_tdata[0];
	assign ms_tick      = s_tdata[1];
	assign read_request = s_tdata[2];

	assign cw       = ucode(step_q);
	assign s_tready = (step_q == STEP_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// counter updates for the item at the input
	always_comb begin
		pc_new = pulse_count_q;
		if (pulse_level && !last_level_q && pulse_count_q != 16'hFFFF) begin
			pc_new = pulse_count_q + 16'd1;
		end
		el_new = elapsed_q;
		iv_new = interval_q;
		if (ms_tick) begin
			if (elapsed_q != 32'hFFFF_FFFF) begin
				el_new = elapsed_q + 32'd1;
			end
			if (interval_q != 16'hFFFF) begin
				iv_new = interval_q + 16'd1;
			end
		end
		hit_count    = (pc_new >= MaxPulses);
		hit_interval = !hit_count && (iv_new >= sample_q);
		upd_new      = read_request && (hit_count || hit_interval);
	end

	// one restoring-division step
	assign rem_sh   = {rem_q, dvd_q[31]};
	assign trial    = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign trial_ge = !trial[33];
	assign prod     = 32'(dvd_q[15:0]) * 32'(RPM_SCALE);

	always_comb begin
		case (cw.cond)
			COND_NEXT: step_d = step_q + step_t'(1);
			COND_GOTO: step_d = cw.target;
			COND_ACCEPT: begin
				if (!in_acc) begin
					step_d = step_q;
				end else if (upd_new) begin
					step_d = step_q + step_t'(1);
				end else begin
					step_d = cw.target;
				end
			end
			COND_LOOP: step_d = (iter_q != ITER_W'(1)) ? cw.target : step_q + step_t'(1);
			COND_OUT:  step_d = (out_full_q && !m_tready) ? step_q : cw.target;
			default:   step_d = STEP_IDLE;
		endcase
	end

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_SAMPLE_TIME_MS) ? {16'd0, sample_q} : {16'd0, ppr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q    <= PPR_RESET;
			sample_q <= SAMPLE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_PPR) begin
				ppr_q <= pwdata[15:0];
			end else begin
				sample_q <= pwdata[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= STEP_IDLE;
			last_level_q  <= 1'b0;
			pulse_count_q <= '0;
			elapsed_q     <= '0;
			interval_q    <= '0;
			held_q        <= '0;
			upd_q         <= 1'b0;
			rem_q         <= '0;
			dvd_q         <= '0;
			dvs_q         <= '0;
			iter_q        <= '0;
			out_full_q    <= 1'b0;
			rpm_q         <= '0;
			updated_q     <= 1'b0;
		end else begin
			step_q <= step_d;
			// drain the output register unless the output step refills it
			if (out_full_q && m_tready && cw.op != OP_OUT) begin
				out_full_q <= 1'b0;
			end
			case (cw.op)
				OP_ACCEPT: begin
					if (in_acc) begin
						last_level_q  <= pulse_level;
						pulse_count_q <= pc_new;
						elapsed_q     <= el_new;
						interval_q    <= (read_request && hit_interval) ? 16'd0 : iv_new;
						upd_q         <= upd_new;
					end
				end
				OP_LD_REVS: begin
					rem_q  <= '0;
					dvd_q  <= {pulse_count_q, 16'd0};
					dvs_q  <= {16'd0, (ppr_q == 16'd0) ? 16'd1 : ppr_q};
					iter_q <= ITER_REVS;
				end
				OP_DIV: begin
					rem_q  <= trial_ge ? trial[31:0] : rem_sh[31:0];
					dvd_q  <= {dvd_q[30:0], trial_ge};
					iter_q <= iter_q - ITER_W'(1);
				end
				OP_MUL: begin
					rem_q  <= '0;
					dvd_q  <= prod;
					dvs_q  <= elapsed_q;
					iter_q <= ITER_RPM;
				end
				OP_SAT: begin
					held_q        <= (elapsed_q == 32'd0 || dvd_q[31:16] != 16'd0)
						? RPM_SAT : dvd_q[15:0];
					pulse_count_q <= '0;
					elapsed_q     <= '0;
				end
				OP_OUT: begin
					if (!out_full_q || m_tready) begin
						out_full_q <= 1'b1;
						rpm_q      <= held_q;
						updated_q  <= upd_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = out_full_q;
	assign m_tdata  = rpm_q;
	assign m_tuser  = updated_q;

	// an item without a recomputation, accepted while the output register is empty, reaches it through the output step
	a_fast_path: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !upd_new && !out_full_q) |=> ##1 m_tvalid)
		else $error("plain item did not reach the output register");

	// divide loop never runs on an exhausted iteration count
	a_iter_live: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_DIV1 || step_q == STEP_DIV2) |-> (iter_q != '0))
		else $error("divide step with zero iteration count");

	// recomputation restarts the measurement
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_SAT) |=> (pulse_count_q == 16'd0 && elapsed_q == 32'd0))
		else $error("count or elapsed time not restarted");

endmodule
